/* design/ffca_pkg.sv */
package ffca_pkg;

  // Heap geometry
  localparam int unsigned NUM_CHUNKS  = 64;
  localparam int unsigned CHUNK_BYTES = 512;

  // Field widths fixed by the interface
  localparam int unsigned SIZE_W  = 16;
  localparam int unsigned START_W = 6;
  localparam int unsigned ADDR_W  = 16;

  // Derived widths
  localparam int unsigned IDX_W   = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
  localparam int unsigned CNT_W   = $clog2(NUM_CHUNKS + 1);
  localparam int unsigned BYTES_W = $clog2(NUM_CHUNKS * CHUNK_BYTES + 1);
  localparam int unsigned CMP_W   = (BYTES_W > SIZE_W) ? BYTES_W : SIZE_W;
  localparam int unsigned PROD_W  = IDX_W + $clog2(CHUNK_BYTES + 1);

  localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(NUM_CHUNKS - 1);
  localparam logic [BYTES_W-1:0] CB_STEP  = BYTES_W'(CHUNK_BYTES);

  // Item kinds
  typedef enum logic {
    KIND_INIT  = 1'b0,
    KIND_ALLOC = 1'b1
  } kind_e;

  // One owner table entry
  typedef struct packed {
    logic             used;
    logic [IDX_W-1:0] owner;
  } entry_t;

  // Table access from the controller
  typedef struct packed {
    logic             we;
    logic             re;
    logic [IDX_W-1:0] addr;
    entry_t           wdata;
  } mem_req_t;

  // Result beat
  typedef struct packed {
    logic               vld;
    logic               ok;
    logic [START_W-1:0] start;
    logic [ADDR_W-1:0]  addr;
  } res_t;

endpackage

/* design/ffca_table.sv */
module ffca_table import ffca_pkg::*; (
  input  logic     clk_i,
  input  mem_req_t req_i,
  output entry_t   rdata_o
);

  entry_t mem [NUM_CHUNKS];
  entry_t rdata_q;

  // Single port, registered read
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/ffca_ctrl.sv */
module ffca_ctrl import ffca_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              kind_i,
  input  logic [SIZE_W-1:0] size_i,
  input  logic [ADDR_W-1:0] heap_base_i,
  input  entry_t            rdata_i,
  output mem_req_t          req_o,
  output logic              busy_o,
  output res_t              res_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_FILL = 4'b0010,
    S_SCAN = 4'b0100,
    S_MARK = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [SIZE_W-1:0]   size_q, size_d;
  logic [IDX_W-1:0]    addr_q, addr_d;
  logic [BYTES_W-1:0]  pos_q, pos_d;
  logic [BYTES_W-1:0]  run_bytes_q, run_bytes_d;
  logic [CNT_W-1:0]    run_cnt_q, run_cnt_d;
  logic [IDX_W-1:0]    start_q, start_d;
  logic                report_q, report_d;
  logic                issue_q, issue_d;
  logic                rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]    rd_idx_q, rd_idx_d;
  res_t                res_q, res_d;

  logic [BYTES_W-1:0]  fit_sum;
  logic [PROD_W-1:0]   offset;
  logic                matched;

  assign fit_sum = run_bytes_q + CB_STEP;
  assign offset  = PROD_W'(start_q) * PROD_W'(CHUNK_BYTES);

  always_comb begin
    state_d     = state_q;
    size_d      = size_q;
    addr_d      = addr_q;
    pos_d       = pos_q;
    run_bytes_d = run_bytes_q;
    run_cnt_d   = run_cnt_q;
    start_d     = start_q;
    report_d    = report_q;
    issue_d     = issue_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    res_d       = '0;
    req_o       = '0;
    matched     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          size_d = size_i;
          addr_d = '0;
          pos_d  = '0;
          if (kind_i == KIND_INIT) begin
            report_d = 1'b1;
            state_d  = S_FILL;
          end else if (size_i == '0) begin
            // empty request fails at once
            res_d.vld = 1'b1;
          end else begin
            issue_d     = 1'b1;
            run_bytes_d = '0;
            run_cnt_d   = '0;
            state_d     = S_SCAN;
          end
        end
      end

      // Sweep: entry i is owned by chunk 0 while i*CHUNK_BYTES < size
      S_FILL: begin
        req_o.we          = 1'b1;
        req_o.addr        = addr_q;
        req_o.wdata.used  = CMP_W'(pos_q) < CMP_W'(size_q);
        req_o.wdata.owner = '0;
        pos_d  = pos_q + CB_STEP;
        addr_d = addr_q + 1'b1;
        if (addr_q == LAST_IDX) begin
          state_d = S_IDLE;
          if (report_q) begin
            res_d.vld = 1'b1;
            res_d.ok  = 1'b1;
          end
        end
      end

      // Streamed reads, one entry a cycle; each entry is checked once its registered read returns
      S_SCAN: begin
        req_o.re   = issue_q;
        req_o.addr = addr_q;
        rd_vld_d   = issue_q;
        rd_idx_d   = addr_q;
        if (issue_q) begin
          addr_d = addr_q + 1'b1;
          if (addr_q == LAST_IDX) begin
            issue_d = 1'b0;
          end
        end
        if (rd_vld_q) begin
          if (rdata_i.used) begin
            run_bytes_d = '0;
            run_cnt_d   = '0;
          end else begin
            if (run_cnt_q == '0) begin
              start_d = rd_idx_q;
            end
            run_bytes_d = fit_sum;
            run_cnt_d   = run_cnt_q + 1'b1;
            if (CMP_W'(fit_sum) >= CMP_W'(size_q)) begin
              matched = 1'b1;
              state_d = S_MARK;
              addr_d  = (run_cnt_q == '0) ? rd_idx_q : start_q;
            end
          end
          if (!matched && rd_idx_q == LAST_IDX) begin
            res_d.vld = 1'b1;
            state_d   = S_IDLE;
          end
        end
      end

      // Claim the run, one entry a cycle
      S_MARK: begin
        req_o.we          = 1'b1;
        req_o.addr        = addr_q;
        req_o.wdata.used  = 1'b1;
        req_o.wdata.owner = start_q;
        addr_d    = addr_q + 1'b1;
        run_cnt_d = run_cnt_q - 1'b1;
        if (run_cnt_q == CNT_W'(1)) begin
          res_d.vld   = 1'b1;
          res_d.ok    = 1'b1;
          res_d.start = START_W'(start_q);
          res_d.addr  = heap_base_i + ADDR_W'(offset);
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Reset starts a silent clearing sweep with a zero preallocation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_FILL;
      size_q   <= '0;
      addr_q   <= '0;
      pos_q    <= '0;
      report_q <= 1'b0;
      issue_q  <= 1'b0;
      rd_vld_q <= 1'b0;
      res_q    <= '0;
    end else begin
      state_q  <= state_d;
      size_q   <= size_d;
      addr_q   <= addr_d;
      pos_q    <= pos_d;
      report_q <= report_d;
      issue_q  <= issue_d;
      rd_vld_q <= rd_vld_d;
      res_q    <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_bytes_q <= run_bytes_d;
    run_cnt_q   <= run_cnt_d;
    start_q     <= start_d;
    rd_idx_q    <= rd_idx_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign res_o  = res_q;

endmodule

/* design/first_fit_chunk_allocator.sv */
// First-fit chunk allocator.
// Command channel: kind_i/size_bytes_i are taken when start is high and
// busy is low. kind 0 rewrites the owner table, marking the first
// ceil(size/CHUNK_BYTES) chunks (saturating) as owned by chunk 0; kind 1
// finds the lowest run of free chunks that covers size_bytes_i and claims it.
// Result channel: one beat per command, done_o high for exactly one cycle with
// success_o, start_chunk_o and address_o; failures report all zeros. The
// receiver cannot stall; a result beat overlaps acceptance of the next command.
// Config channel: cfg_data_i is written to heap_base when cfg_valid_i is high;
// cfg_ready_o is always high. Write only while idle.
// Sequencing (the owner table has one port, so scan and claim run in turn):
//   init             writes every entry of the table in order
//   alloc, zero size failure beat, the table is not touched
//   alloc, no fit    full scan of the table, then a failure beat
//   alloc, found     scan up to the run's end, then one write per claimed
//                    chunk; the result beat follows the last claim
// Reset: a sweep over all NUM_CHUNKS entries clears the table with busy
// high and no result beat; heap_base resets to 0.
module first_fit_chunk_allocator import ffca_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               kind_i,
  input  logic [SIZE_W-1:0]  size_bytes_i,
  output logic               done_o,
  output logic               success_o,
  output logic [START_W-1:0] start_chunk_o,
  output logic [ADDR_W-1:0]  address_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [ADDR_W-1:0]  cfg_data_i
);

  logic [ADDR_W-1:0] heap_base_q;
  mem_req_t          mem_req;
  entry_t            mem_rdata;
  res_t              res;

  // Config register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q <= '0;
    end else if (cfg_valid_i) begin
      heap_base_q <= cfg_data_i;
    end
  end

  ffca_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .kind_i      (kind_i),
    .size_i      (size_bytes_i),
    .heap_base_i (heap_base_q),
    .rdata_i     (mem_rdata),
    .req_o       (mem_req),
    .busy_o      (busy),
    .res_o       (res)
  );

  ffca_table u_table (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  assign done_o        = res.vld;
  assign success_o     = res.ok;
  assign start_chunk_o = res.start;
  assign address_o     = res.addr;

  // Failed beats carry zeros
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !success_o |-> start_chunk_o == '0 && address_o == '0)
    else $error("failed result carries nonzero payload");

  // Empty alloc answers in the next cycle with a failure
  a_empty_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && kind_i == KIND_ALLOC && size_bytes_i == '0
      |=> done_o && !success_o)
    else $error("zero-size alloc not rejected");

  // Table only changes while busy (a command or the reset sweep in flight)
  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we |-> busy)
    else $error("table write while idle");

  // No read and write in the same cycle
  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req.we && mem_req.re))
    else $error("table read and write collide");

endmodule
